### rtl/core/lse_pkg.sv
// Package with shared constants, register codes and result types of the LSB text extractor.
`default_nettype none
package lse_pkg;

  localparam int unsigned CHAN_W   = 8;   // width of one colour channel field
  localparam int unsigned BPC_W    = 4;   // bits_per_channel register width
  localparam int unsigned LEN_W    = 27;  // message_length register and byte counter width
  localparam int unsigned BYTE_W   = 8;   // one text byte
  localparam int unsigned NLANES   = 3;   // red, green, blue
  localparam int unsigned ACC_W    = 7;   // leftover stream bits between pixels
  localparam int unsigned HELD_W   = 3;   // count of leftover bits, 0..7
  localparam int unsigned CNT_W    = 2;   // bytes per pixel, 0..3
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BPC_W-1:0] MAX_K = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPC     = 1'b0,
    REG_MSG_LEN = 1'b1
  } cfg_reg_e;

  // Bytes released by one pixel, earliest byte in slot 0.
  typedef struct packed {
    logic [NLANES-1:0][BYTE_W-1:0] bytes;
    logic [NLANES-1:0]             mend;
    logic [CNT_W-1:0]              cnt;
  } grp_t;

  // Everything the merge stage hands back for one pixel.
  typedef struct packed {
    grp_t              grp;
    logic [ACC_W-1:0]  acc;
    logic [HELD_W-1:0] held;
    logic [LEN_W-1:0]  emitted;
  } mrg_t;

endpackage
`default_nettype wire

### rtl/core/lse_ifs.sv
// Valid/ready channel interfaces for pixel items and text byte items.
`default_nettype none
interface lse_pix_if;
  import lse_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              first_pixel;

  modport source (output valid, red, green, blue, first_pixel, input ready);
  modport sink   (input valid, red, green, blue, first_pixel, output ready);
endinterface

interface lse_txt_if;
  import lse_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last_of_pixel;
  logic              message_end;

  modport source (output valid, text_byte, last_of_pixel, message_end, input ready);
  modport sink   (input valid, text_byte, last_of_pixel, message_end, output ready);
endinterface
`default_nettype wire

### rtl/core/lse_lane.sv
// One channel lane: takes the low K bits of a channel, bit 0 first in stream order.
`default_nettype none
module lse_lane import lse_pkg::*; (
  input  logic [CHAN_W-1:0] chan_i,
  input  logic [BPC_W-1:0]  k_i,
  output logic [CHAN_W-1:0] seg_o
);

  logic [CHAN_W-1:0] rev;

  always_comb begin
    for (int b = 0; b < CHAN_W; b++) begin
      rev[CHAN_W-1-b] = chan_i[b];
    end
  end

  // Right-align the K stream bits; K of zero shifts everything out.
  assign seg_o = rev >> (MAX_K - k_i);

endmodule
`default_nettype wire

### rtl/core/lse_merge.sv
// Merge stage: joins the lane segments with leftover bits and cuts whole bytes.
`default_nettype none
module lse_merge import lse_pkg::*; (
  input  logic [NLANES-1:0][CHAN_W-1:0] seg_i,
  input  logic [BPC_W-1:0]              k_i,
  input  logic                          first_i,
  input  logic [ACC_W-1:0]              acc_i,
  input  logic [HELD_W-1:0]             held_i,
  input  logic [LEN_W-1:0]              emitted_i,
  input  logic [LEN_W-1:0]              msg_len_i,
  output mrg_t                          res_o
);

  logic [ACC_W-1:0]  a;
  logic [HELD_W-1:0] h;
  logic [LEN_W-1:0]  e;
  logic [4:0]        k1, k2, k3, tot, sh;
  logic [23:0]       nstr;
  logic [30:0]       v, vs;
  logic [CNT_W-1:0]  nb, cnt;
  logic [HELD_W-1:0] rem;
  logic [LEN_W-1:0]  diff;
  logic              open;

  always_comb begin
    a = first_i ? '0 : acc_i;
    h = first_i ? '0 : held_i;
    e = first_i ? '0 : emitted_i;

    k1 = {1'b0, k_i};
    k2 = k1 << 1;
    k3 = k2 + k1;

    // New stream bits, earliest in the highest position.
    nstr = ({16'b0, seg_i[0]} << k2) | ({16'b0, seg_i[1]} << k1) | {16'b0, seg_i[2]};
    v    = ({24'b0, a} << k3) | {7'b0, nstr};

    tot = {2'b0, h} + k3;
    nb  = tot[4:3];
    rem = tot[2:0];

    res_o = '0;
    for (int j = 0; j < NLANES; j++) begin
      sh = {2'b0, rem} + {nb - CNT_W'(j) - 2'd1, 3'b000};
      vs = v >> sh;
      res_o.grp.bytes[j] = vs[BYTE_W-1:0];
    end

    // Bytes past the message length are dropped.
    open = (e < msg_len_i);
    diff = msg_len_i - e;
    if (!open) begin
      cnt = '0;
    end else if (diff >= {25'b0, nb}) begin
      cnt = nb;
    end else begin
      cnt = diff[CNT_W-1:0];
    end
    for (int j = 0; j < NLANES; j++) begin
      res_o.grp.mend[j] = open && (diff == LEN_W'(j + 1));
    end

    res_o.grp.cnt = cnt;
    res_o.acc     = v[ACC_W-1:0] & ~(7'h7f << rem);
    res_o.held    = rem;
    res_o.emitted = e + {25'b0, cnt};
  end

endmodule
`default_nettype wire

### rtl/core/lsb_stego_text_extractor.sv
// Top level of the LSB text extractor: lanes, merge stage and byte output register.
// Data path: an accepted pixel sits in the lane register and is merged into the output
// register once that register is free, and its bytes are then offered from the output register.
// Throughput: one pixel per cycle while pixels yield at most one byte and the output is not
// stalled; a pixel that yields more bytes holds the output register until its last byte leaves.
// Reset (rst_ni low, asynchronous) empties both stages, clears the bit accumulator and the
// byte count, and sets bits_per_channel to 1 and message_length to 0.
`default_nettype none
module lsb_stego_text_extractor import lse_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  lse_pix_if.sink                   pix,
  lse_txt_if.source                 txt,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LEN_W-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [BPC_W-1:0] bpc_q;
  logic [LEN_W-1:0] len_q;

  // Lane register: the three channel segments of one accepted pixel.
  logic                          s1_valid_q;
  logic [NLANES-1:0][CHAN_W-1:0] s1_seg_q;
  logic [BPC_W-1:0]              s1_k_q;
  logic                          s1_first_q;

  // Stream state carried from pixel to pixel.
  logic [ACC_W-1:0]  acc_q;
  logic [HELD_W-1:0] held_q;
  logic [LEN_W-1:0]  emitted_q;

  // Output register: the bytes of one pixel, handed out one per cycle while the output is not stalled.
  logic             grp_valid_q;
  grp_t             grp_q;
  logic [CNT_W-1:0] idx_q;

  logic [NLANES-1:0][CHAN_W-1:0] chan, seg;
  logic [BPC_W-1:0]              k_eff;
  mrg_t                          mrg;
  logic                          pix_acc, txt_acc, grp_last, grp_free, s1_adv;

  assign chan[0] = pix.red;
  assign chan[1] = pix.green;
  assign chan[2] = pix.blue;

  // A K beyond the channel width takes the whole channel.
  assign k_eff = (bpc_q > MAX_K) ? MAX_K : bpc_q;

  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    lse_lane u_lane (
      .chan_i (chan[l]),
      .k_i    (k_eff),
      .seg_o  (seg[l])
    );
  end

  lse_merge u_merge (
    .seg_i     (s1_seg_q),
    .k_i       (s1_k_q),
    .first_i   (s1_first_q),
    .acc_i     (acc_q),
    .held_i    (held_q),
    .emitted_i (emitted_q),
    .msg_len_i (len_q),
    .res_o     (mrg)
  );

  // The output register frees up when it is empty or its last byte leaves this cycle.
  // The lane register moves on whenever the output register is free, even for a pixel
  // that yields no byte, so the stream state always advances in pixel order.
  assign grp_last  = (idx_q == grp_q.cnt - 2'd1);
  assign txt_acc   = txt.valid && txt.ready;
  assign grp_free  = !grp_valid_q || (txt.ready && grp_last);
  assign s1_adv    = s1_valid_q && grp_free;
  assign pix.ready = !s1_valid_q || grp_free;
  assign pix_acc   = pix.valid && pix.ready;

  assign txt.valid         = grp_valid_q;
  assign txt.text_byte     = grp_q.bytes[idx_q];
  assign txt.last_of_pixel = grp_last;
  assign txt.message_end   = grp_q.mend[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpc_q <= BPC_W'(1);
      len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BPC:     bpc_q <= cfg_data_i[BPC_W-1:0];
        REG_MSG_LEN: len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      acc_q       <= '0;
      held_q      <= '0;
      emitted_q   <= '0;
      grp_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (pix_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        acc_q     <= mrg.acc;
        held_q    <= mrg.held;
        emitted_q <= mrg.emitted;
      end

      // A pixel that yields bytes loads the output register as the old group leaves.
      if (s1_adv && (mrg.grp.cnt != '0)) begin
        grp_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (txt_acc) begin
        if (grp_last) begin
          grp_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  // Payload registers follow their valid bits and need no reset.
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_seg_q   <= seg;
      s1_k_q     <= k_eff;
      s1_first_q <= pix.first_pixel;
    end
    if (s1_adv && (mrg.grp.cnt != '0)) begin
      grp_q <= mrg.grp;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lse_checker.sv
// Port-level checker for the LSB text extractor and its bind statement.
`default_nettype none
module lse_checker import lse_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [BYTE_W-1:0] out_byte_i,
  input wire logic              out_last_i,
  input wire logic              out_end_i
);

  // A stalled byte item stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item withdrawn while stalled");

  // A stalled byte item keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_byte_i) && $stable(out_last_i) && $stable(out_end_i))
    else $error("output payload changed while stalled");

  // The bytes of one pixel are offered without gaps.
  a_group_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside the bytes of one pixel");

  // Input is only held off while bytes are waiting at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no output pending");

endmodule

bind lsb_stego_text_extractor lse_checker u_lse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix.ready),
  .out_valid_i (txt.valid),
  .out_ready_i (txt.ready),
  .out_byte_i  (txt.text_byte),
  .out_last_i  (txt.last_of_pixel),
  .out_end_i   (txt.message_end)
);
`default_nettype wire
